// ===== design/png_stored_deflate_encoder_unit_assert.svh =====
// Assertion macros shared by the PNG stored-deflate encoder RTL.
// The including module must provide clk_i and rst_ni.
`ifndef PNG_STORED_DEFLATE_ENCODER_UNIT_ASSERT_SVH
`define PNG_STORED_DEFLATE_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PNGSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PNGSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pngse_pkg.sv =====
// Package for the PNG stored-deflate encoder: widths, PNG/zlib constants,
// sequencer and register codes, shared structs and the byte-wise CRC-32 helper.
// Depends on nothing.
package pngse_pkg;

  localparam int unsigned MaxDim = 8192;
  localparam int DimW    = 14;
  localparam int RowPosW = 15;
  localparam int TotalW  = 28;
  localparam int BlocksW = 13;
  localparam int IdxW    = 6;
  localparam int CfgIdxW = 2;

  localparam logic [DimW-1:0] MaxDimV  = DimW'(MaxDim);
  localparam logic [31:0]     CrcPoly  = 32'hEDB88320;
  localparam logic [31:0]     CrcInit  = 32'hFFFFFFFF;
  localparam logic [16:0]     AdlerMod = 17'd65521;
  localparam logic [16:0]     StoredMax = 17'd65535;

  localparam logic [7:0] PngSig [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                        8'd13, 8'd10, 8'd26, 8'd10};
  localparam logic [31:0] IhdrLen   = 32'd13;
  localparam logic [31:0] ChunkIhdr = 32'h49484452;
  localparam logic [31:0] ChunkIdat = 32'h49444154;
  localparam logic [31:0] ChunkIend = 32'h49454E44;
  localparam logic [7:0]  IhdrDepth = 8'd8;
  localparam logic [7:0]  IhdrColor = 8'd2;
  localparam logic [7:0]  ZlibCmf   = 8'h78;
  localparam logic [7:0]  ZlibFlg   = 8'h01;

  localparam logic [IdxW-1:0] HeadLast = IdxW'(42);
  localparam logic [IdxW-1:0] BlkLast  = IdxW'(4);
  localparam logic [IdxW-1:0] TailLast = IdxW'(19);

  typedef enum logic [1:0] {
    S_HEAD,
    S_RAW,
    S_TAIL
  } step_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [DimW-1:0]    width;
    logic [DimW-1:0]    height;
    logic [RowPosW-1:0] row_len;
    logic [TotalW-1:0]  raw_total;
    logic [31:0]        idat_length;
  } geom_t;

  typedef struct packed {
    logic byte_en;
    logic crc_en;
    logic crc_restart;
    logic raw_en;
    logic adler_clear;
  } cksum_ctl_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > MaxDimV) begin
      r = MaxDimV;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== design/pngse_geom.sv =====
// Image geometry: configuration registers, per-image latch of the clamped size,
// and a short register pipeline for the raw byte total and the IDAT length.
// Depends on pngse_pkg.
module pngse_geom import pngse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  input  logic               start_i,
  output geom_t              geom_o
);

  logic [DimW-1:0]    cfg_w_q, cfg_w_d, cfg_h_q, cfg_h_d;
  logic [DimW-1:0]    w_q, w_d, h_q, h_d;
  logic [RowPosW-1:0] row_len_q, row_len_d;
  logic [TotalW-1:0]  raw_q, raw_d;
  logic [BlocksW-1:0] blocks_q, blocks_d;
  logic [31:0]        idat_q, idat_d;
  logic [TotalW-1:0]  row_ext;
  logic [11:0]        quo_hi;
  logic [16:0]        rem_sum;
  logic [16:0]        rem_fix;
  logic [BlocksW-1:0] quo;

  always_comb begin
    cfg_w_d = cfg_w_q;
    cfg_h_d = cfg_h_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegWidth:  cfg_w_d = cfg_data_i;
        RegHeight: cfg_h_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_d = start_i ? clamp_dim(cfg_w_q) : w_q;
    h_d = start_i ? clamp_dim(cfg_h_q) : h_q;
    row_len_d = RowPosW'({w_q, 1'b0}) + RowPosW'(w_q);
    row_ext = TotalW'(row_len_q) + TotalW'(1);
    raw_d = row_ext * TotalW'(h_q);
    quo_hi = raw_q[TotalW-1:16];
    rem_sum = 17'(quo_hi) + 17'(raw_q[15:0]);
    if (rem_sum >= StoredMax) begin
      quo = BlocksW'(quo_hi) + BlocksW'(1);
      rem_fix = rem_sum - StoredMax;
    end else begin
      quo = BlocksW'(quo_hi);
      rem_fix = rem_sum;
    end
    blocks_d = quo + BlocksW'(rem_fix != '0);
    idat_d = 32'd6 + 32'(raw_q) + 32'({blocks_q, 2'b00}) + 32'(blocks_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q   <= DimW'(1);
      cfg_h_q   <= DimW'(1);
      w_q       <= DimW'(1);
      h_q       <= DimW'(1);
      row_len_q <= RowPosW'(3);
      raw_q     <= TotalW'(4);
      blocks_q  <= BlocksW'(1);
      idat_q    <= 32'd15;
    end else begin
      cfg_w_q   <= cfg_w_d;
      cfg_h_q   <= cfg_h_d;
      w_q       <= w_d;
      h_q       <= h_d;
      row_len_q <= row_len_d;
      raw_q     <= raw_d;
      blocks_q  <= blocks_d;
      idat_q    <= idat_d;
    end
  end

  assign geom_o.width       = w_q;
  assign geom_o.height      = h_q;
  assign geom_o.row_len     = row_len_q;
  assign geom_o.raw_total   = raw_q;
  assign geom_o.idat_length = idat_q;

endmodule

// ===== design/pngse_cksum.sv =====
// Running checksums of the output stream: chunk CRC-32 over typed bytes and
// Adler-32 over the raw zlib payload, one byte per cycle when byte_en is set.
// Depends on pngse_pkg.
module pngse_cksum import pngse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cksum_ctl_t  ctl_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o,
  output logic [31:0] adler_o
);

  logic [31:0] crc_q, crc_d;
  logic [15:0] lo_q, lo_d, hi_q, hi_d;
  logic [16:0] lo_sum, lo_mod, hi_sum;

  always_comb begin
    crc_d = crc_q;
    if (ctl_i.byte_en && ctl_i.crc_en) begin
      crc_d = crc_byte(ctl_i.crc_restart ? CrcInit : crc_q, data_i);
    end
  end

  always_comb begin
    lo_sum = 17'(lo_q) + 17'(data_i);
    lo_mod = (lo_sum >= AdlerMod) ? (lo_sum - AdlerMod) : lo_sum;
    hi_sum = 17'(hi_q) + lo_mod;
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctl_i.adler_clear) begin
      lo_d = 16'd1;
      hi_d = 16'd0;
    end else if (ctl_i.byte_en && ctl_i.raw_en) begin
      lo_d = lo_mod[15:0];
      hi_d = (hi_sum >= AdlerMod) ? 16'(hi_sum - AdlerMod) : hi_sum[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
      lo_q  <= 16'd1;
      hi_q  <= 16'd0;
    end else begin
      crc_q <= crc_d;
      lo_q  <= lo_d;
      hi_q  <= hi_d;
    end
  end

  assign crc_o   = crc_q;
  assign adler_o = {hi_q, lo_q};

endmodule

// ===== design/png_stored_deflate_encoder_unit.sv =====
// PNG stored-deflate encoder top level: input register, byte sequencer and
// output register. Depends on pngse_pkg, pngse_geom and pngse_cksum.
//
// Usage: pixel bytes (R, G, B, rows top first) enter on the pixel channel; the
// PNG file leaves one byte per transaction on the out channel. last_of_run_o
// marks the final byte caused by one pixel byte, end_of_image_o the last byte
// of the file. image_width (index 0) and image_height (index 1) are written on
// the cfg channel between images; the size is taken when an image starts.
// Each pixel byte sits in an input register while the sequencer produces its
// bytes, one per cycle, into the output register. The first byte of a row is
// preceded by a filter byte, and a stored block header comes where a block
// starts; the signature, IHDR, IDAT and zlib headers precede an image's first
// byte, the Adler-32, IDAT CRC and IEND chunk follow its last. The output
// register sets the rate at one byte per cycle; the next pixel byte is accepted
// in the cycle that the current one produces its last byte. A stalled receiver
// holds the output register and stops the sequencer. Reset leaves the block
// idle, waiting for the first byte of an image, with both dimensions set to 1.
`include "png_stored_deflate_encoder_unit_assert.svh"

module png_stored_deflate_encoder_unit import pngse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pixel_valid_i,
  output logic               pixel_ready_o,
  input  logic [7:0]         pixel_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o,
  output logic               end_of_image_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i
);

  geom_t      geom;
  cksum_ctl_t ck_ctl;
  logic [31:0] crc, adler;

  logic              in_valid_q, in_valid_d;
  logic [7:0]        pix_q, pix_d;
  step_e             step_q, step_d;
  logic [IdxW-1:0]   run_idx_q, run_idx_d;
  logic [15:0]       block_left_q, block_left_d;
  logic [TotalW-1:0] bytes_done_q, bytes_done_d;
  logic [RowPosW-1:0] row_pos_q, row_pos_d;
  logic [DimW-1:0]   rows_left_q, rows_left_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              out_eoi_q, out_eoi_d;

  logic              out_free, fire, accept;
  logic              blk_hdr, blk_final, row_start, row_end;
  logic [TotalW-1:0] left;
  logic [15:0]       blk_len;
  logic [7:0]        cur_byte;
  logic              crc_en, crc_restart, raw_en, item_end, to_tail, image_end;

  assign out_free = !out_valid_q || out_ready_i;
  assign fire     = in_valid_q && out_free;
  assign pixel_ready_o = !in_valid_q || (out_free && item_end);
  assign accept   = pixel_valid_i && pixel_ready_o;
  assign cfg_ready_o = 1'b1;

  assign blk_hdr   = (block_left_q == '0);
  assign left      = geom.raw_total - bytes_done_q;
  assign blk_final = (left <= TotalW'(StoredMax));
  assign blk_len   = blk_final ? left[15:0] : StoredMax[15:0];
  assign row_start = (row_pos_q == '0);
  assign row_end   = (row_pos_q == geom.row_len);

  pngse_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (fire && (step_q == S_HEAD) && (run_idx_q == '0)),
    .geom_o      (geom)
  );

  always_comb begin
    ck_ctl.byte_en     = fire;
    ck_ctl.crc_en      = crc_en;
    ck_ctl.crc_restart = crc_restart;
    ck_ctl.raw_en      = raw_en;
    ck_ctl.adler_clear = fire && (step_q == S_HEAD) && (run_idx_q == HeadLast);
  end

  pngse_cksum u_cksum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ck_ctl),
    .data_i  (cur_byte),
    .crc_o   (crc),
    .adler_o (adler)
  );

  // Byte selection and per-byte flags for the current sequencer position.
  always_comb begin
    cur_byte    = 8'd0;
    crc_en      = 1'b0;
    crc_restart = 1'b0;
    raw_en      = 1'b0;
    item_end    = 1'b0;
    to_tail     = 1'b0;
    image_end   = 1'b0;
    case (step_q)
      S_HEAD: begin
        case (run_idx_q) inside
          [6'd0:6'd7]:   cur_byte = PngSig[run_idx_q[2:0]];
          [6'd8:6'd11]:  cur_byte = be_byte(IhdrLen, run_idx_q[1:0]);
          [6'd12:6'd15]: begin
            cur_byte    = be_byte(ChunkIhdr, run_idx_q[1:0]);
            crc_en      = 1'b1;
            crc_restart = (run_idx_q == 6'd12);
          end
          [6'd16:6'd19]: begin
            cur_byte = be_byte(32'(geom.width), run_idx_q[1:0]);
            crc_en   = 1'b1;
          end
          [6'd20:6'd23]: begin
            cur_byte = be_byte(32'(geom.height), run_idx_q[1:0]);
            crc_en   = 1'b1;
          end
          6'd24: begin
            cur_byte = IhdrDepth;
            crc_en   = 1'b1;
          end
          6'd25: begin
            cur_byte = IhdrColor;
            crc_en   = 1'b1;
          end
          [6'd26:6'd28]: crc_en = 1'b1;
          [6'd29:6'd32]: cur_byte = be_byte(crc ^ CrcInit, 2'(run_idx_q - 6'd29));
          [6'd33:6'd36]: cur_byte = be_byte(geom.idat_length, 2'(run_idx_q - 6'd33));
          [6'd37:6'd40]: begin
            cur_byte    = be_byte(ChunkIdat, 2'(run_idx_q - 6'd37));
            crc_en      = 1'b1;
            crc_restart = (run_idx_q == 6'd37);
          end
          6'd41: begin
            cur_byte = ZlibCmf;
            crc_en   = 1'b1;
          end
          6'd42: begin
            cur_byte = ZlibFlg;
            crc_en   = 1'b1;
          end
          default: cur_byte = 8'd0;
        endcase
      end
      S_RAW: begin
        crc_en = 1'b1;
        if (blk_hdr) begin
          case (run_idx_q)
            6'd0:    cur_byte = {7'd0, blk_final};
            6'd1:    cur_byte = blk_len[7:0];
            6'd2:    cur_byte = blk_len[15:8];
            6'd3:    cur_byte = ~blk_len[7:0];
            6'd4:    cur_byte = ~blk_len[15:8];
            default: cur_byte = 8'd0;
          endcase
        end else begin
          raw_en   = 1'b1;
          cur_byte = row_start ? 8'd0 : pix_q;
          if (!row_start) begin
            to_tail  = row_end && (rows_left_q == DimW'(1));
            item_end = !to_tail;
          end
        end
      end
      S_TAIL: begin
        case (run_idx_q) inside
          [6'd0:6'd3]: begin
            cur_byte = be_byte(adler, run_idx_q[1:0]);
            crc_en   = 1'b1;
          end
          [6'd4:6'd7]:   cur_byte = be_byte(crc ^ CrcInit, run_idx_q[1:0]);
          [6'd8:6'd11]:  cur_byte = 8'd0;
          [6'd12:6'd15]: begin
            cur_byte    = be_byte(ChunkIend, run_idx_q[1:0]);
            crc_en      = 1'b1;
            crc_restart = (run_idx_q == 6'd12);
          end
          [6'd16:6'd19]: cur_byte = be_byte(crc ^ CrcInit, run_idx_q[1:0]);
          default:       cur_byte = 8'd0;
        endcase
        image_end = (run_idx_q == TailLast);
        item_end  = image_end;
      end
      default: cur_byte = 8'd0;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    step_d    = step_q;
    run_idx_d = run_idx_q;
    if (fire) begin
      case (step_q)
        S_HEAD: begin
          if (run_idx_q == HeadLast) begin
            step_d    = S_RAW;
            run_idx_d = '0;
          end else begin
            run_idx_d = run_idx_q + IdxW'(1);
          end
        end
        S_RAW: begin
          if (blk_hdr) begin
            run_idx_d = (run_idx_q == BlkLast) ? '0 : run_idx_q + IdxW'(1);
          end else if (to_tail) begin
            step_d    = S_TAIL;
            run_idx_d = '0;
          end
        end
        S_TAIL: begin
          if (run_idx_q == TailLast) begin
            step_d    = S_HEAD;
            run_idx_d = '0;
          end else begin
            run_idx_d = run_idx_q + IdxW'(1);
          end
        end
        default: begin
          step_d    = S_HEAD;
          run_idx_d = '0;
        end
      endcase
    end
  end

  // Image counters.
  always_comb begin
    block_left_d = block_left_q;
    bytes_done_d = bytes_done_q;
    row_pos_d    = row_pos_q;
    rows_left_d  = rows_left_q;
    if (fire) begin
      if ((step_q == S_HEAD) && (run_idx_q == HeadLast)) begin
        block_left_d = '0;
        bytes_done_d = '0;
        row_pos_d    = '0;
        rows_left_d  = geom.height;
      end else if (step_q == S_RAW) begin
        if (blk_hdr) begin
          if (run_idx_q == BlkLast) begin
            block_left_d = blk_len;
          end
        end else begin
          bytes_done_d = bytes_done_q + TotalW'(1);
          block_left_d = block_left_q - 16'd1;
          if (row_start) begin
            row_pos_d = RowPosW'(1);
          end else if (row_end) begin
            row_pos_d   = '0;
            rows_left_d = rows_left_q - DimW'(1);
          end else begin
            row_pos_d = row_pos_q + RowPosW'(1);
          end
        end
      end
    end
  end

  // Input and output registers.
  always_comb begin
    in_valid_d = in_valid_q;
    pix_d      = pix_q;
    if (accept) begin
      in_valid_d = 1'b1;
      pix_d      = pixel_byte_i;
    end else if (fire && item_end) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_eoi_d   = out_eoi_q;
    if (fire) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_last_d  = item_end;
      out_eoi_d   = image_end;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      step_q       <= S_HEAD;
      run_idx_q    <= '0;
      block_left_q <= '0;
      bytes_done_q <= '0;
      row_pos_q    <= '0;
      rows_left_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      step_q       <= step_d;
      run_idx_q    <= run_idx_d;
      block_left_q <= block_left_d;
      bytes_done_q <= bytes_done_d;
      row_pos_q    <= row_pos_d;
      rows_left_q  <= rows_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q      <= pix_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_eoi_q  <= out_eoi_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_run_o  = out_last_q;
  assign end_of_image_o = out_eoi_q;

  `PNGSE_ASSERT_IMP(a_eoi_is_last, out_valid_o && end_of_image_o, last_of_run_o,
    "end of image without end of run")
  `PNGSE_ASSERT_IMP(a_head_idx, step_q == S_HEAD, run_idx_q <= HeadLast,
    "header index out of range")
  `PNGSE_ASSERT_IMP(a_tail_idx, step_q == S_TAIL, run_idx_q <= TailLast,
    "trailer index out of range")
  `PNGSE_ASSERT_IMP(a_blk_room, in_valid_q && (step_q == S_RAW) && blk_hdr,
    geom.raw_total > bytes_done_q, "stored block header with no raw bytes left")
  `PNGSE_ASSERT_NXT(a_img_start, fire && (step_q == S_HEAD) && (run_idx_q == HeadLast),
    (step_q == S_RAW) && (bytes_done_q == '0) && (block_left_q == '0),
    "image counters not cleared after header")

endmodule
